FILE: sv/box_average_downscale_assert.svh
// assertion macros for the box average downscaler
`ifndef BOX_AVERAGE_DOWNSCALE_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define BAD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("box average downscale assertion failed");

// next-cycle implication, checked out of reset
`define BAD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("box average downscale assertion failed");

`else

`define BAD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define BAD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

FILE: sv/bad_pkg.sv
// shared types, constants and helper functions of the box average downscaler
`default_nettype none

package bad_pkg;

	// configuration port
	localparam int SCALE_W    = 4;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic [SCALE_W-1:0]  SCALE_RST  = 4'd2;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	// limits
	localparam logic [SCALE_W-1:0]  MIN_SCALE      = 4'd2;
	localparam logic [SCALE_W-1:0]  MAX_SCALE      = 4'd8;
	localparam logic [WIDTH_W-1:0]  MAX_OUT_WIDTH  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] MAX_OUT_HEIGHT = 13'd4096;

	// datapath widths
	localparam int LANES  = 3;
	localparam int PIX_W  = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 12;
	localparam int CIB_W  = 3;
	localparam int HSUM_W = 11;
	localparam int CSUM_W = 14;
	localparam int LINE_DEPTH = 1024;

	// reciprocal divider
	localparam int RECIP_W     = 19;
	localparam int RECIP_SHIFT = 20;
	localparam int DIV_W       = 7;
	localparam int QUO_W       = 12;
	localparam int PROD_W      = CSUM_W + RECIP_W;
	localparam int CHK_W       = QUO_W + DIV_W;

	// job queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
		logic             frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             row_end;
		logic             frame_end;
	} pix_out_t;

	typedef logic [LANES-1:0][HSUM_W-1:0] hsum_t;
	typedef logic [LANES-1:0][CSUM_W-1:0] csum_t;

	// one finished horizontal run of a block row
	typedef struct packed {
		hsum_t            hsum;
		logic [COL_W-1:0] idx;
		logic             first_row;
		logic             last_row;
		logic             last_col;
		logic             last_orow;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ADD,
		B_MUL,
		B_FIX
	} bstate_t;

	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
		logic [SCALE_W-1:0] r;
		r = s;
		if (s < MIN_SCALE) begin
			r = MIN_SCALE;
		end else if (s > MAX_SCALE) begin
			r = MAX_SCALE;
		end
		return r;
	endfunction

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		r = w;
		if (w == '0) begin
			r = WIDTH_W'(1);
		end else if (w > MAX_OUT_WIDTH) begin
			r = MAX_OUT_WIDTH;
		end
		return r;
	endfunction

	function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] h);
		logic [HEIGHT_W-1:0] r;
		r = h;
		if (h == '0) begin
			r = HEIGHT_W'(1);
		end else if (h > MAX_OUT_HEIGHT) begin
			r = MAX_OUT_HEIGHT;
		end
		return r;
	endfunction

	// floor(2^20 / s^2) for the clamped scale
	function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] s);
		logic [RECIP_W-1:0] r;
		unique case (s)
			4'd3:    r = 19'd116508;
			4'd4:    r = 19'd65536;
			4'd5:    r = 19'd41943;
			4'd6:    r = 19'd29127;
			4'd7:    r = 19'd21399;
			4'd8:    r = 19'd16384;
			default: r = 19'd262144;
		endcase
		return r;
	endfunction

	// block area s^2 for the clamped scale
	function automatic logic [DIV_W-1:0] area_of(input logic [SCALE_W-1:0] s);
		logic [DIV_W-1:0] r;
		unique case (s)
			4'd3:    r = 7'd9;
			4'd4:    r = 7'd16;
			4'd5:    r = 7'd25;
			4'd6:    r = 7'd36;
			4'd7:    r = 7'd49;
			4'd8:    r = 7'd64;
			default: r = 7'd4;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/bad_front.sv
// front end: pixel counters and horizontal sums, emits one job per block row run
`default_nettype none

module bad_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  bad_pkg::pix_in_t             in_data,
	input  wire [bad_pkg::SCALE_W-1:0]   scale_eff,
	input  wire [bad_pkg::WIDTH_W-1:0]   width_eff,
	input  wire [bad_pkg::HEIGHT_W-1:0]  height_eff,
	input  bad_pkg::qstat_t              qstat,
	output logic                         push,
	output bad_pkg::job_t                job
);
	import bad_pkg::*;

	hsum_t             hp_q;
	logic [CIB_W-1:0]  cib_q;
	logic [COL_W-1:0]  oc_q;
	logic [CIB_W-1:0]  rib_q;
	logic [ROW_W-1:0]  orow_q;

	hsum_t             hp_base;
	hsum_t             hp_new;
	logic [CIB_W-1:0]  cib_base;
	logic [COL_W-1:0]  oc_base;
	logic [CIB_W-1:0]  rib_base;
	logic [ROW_W-1:0]  orow_base;
	logic [CIB_W:0]    cib_inc;
	logic              col_done;
	logic              last_col;
	logic              last_row;
	logic              last_orow;
	logic [PIX_W-1:0]  pix [LANES];
	logic              accept;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	assign pix[0] = in_data.red_in;
	assign pix[1] = in_data.green_in;
	assign pix[2] = in_data.blue_in;

	// frame start restarts every counter before the pixel is counted
	always_comb begin
		hp_base   = in_data.frame_start ? '0 : hp_q;
		cib_base  = in_data.frame_start ? '0 : cib_q;
		oc_base   = in_data.frame_start ? '0 : oc_q;
		rib_base  = in_data.frame_start ? '0 : rib_q;
		orow_base = in_data.frame_start ? '0 : orow_q;
		for (int k = 0; k < LANES; k++) begin
			hp_new[k] = hp_base[k] + HSUM_W'(pix[k]);
		end
	end

	// position tests, a counter past its bound counts as last
	always_comb begin
		cib_inc   = {1'b0, cib_base} + (CIB_W+1)'(1);
		col_done  = !(cib_inc < scale_eff);
		last_col  = ({1'b0, oc_base} + WIDTH_W'(1)) >= width_eff;
		last_row  = ({1'b0, rib_base} + SCALE_W'(1)) >= scale_eff;
		last_orow = ({1'b0, orow_base} + HEIGHT_W'(1)) >= height_eff;
	end

	// job handed to the back end
	always_comb begin
		push          = accept && col_done;
		job.hsum      = hp_new;
		job.idx       = oc_base;
		job.first_row = (rib_base == '0);
		job.last_row  = last_row;
		job.last_col  = last_col;
		job.last_orow = last_orow;
	end

	// counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q   <= '0;
			cib_q  <= '0;
			oc_q   <= '0;
			rib_q  <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (!col_done) begin
				hp_q   <= hp_new;
				cib_q  <= cib_inc[CIB_W-1:0];
				oc_q   <= oc_base;
				rib_q  <= rib_base;
				orow_q <= orow_base;
			end else begin
				hp_q  <= '0;
				cib_q <= '0;
				if (last_col) begin
					oc_q <= '0;
					if (last_row) begin
						rib_q  <= '0;
						orow_q <= last_orow ? '0 : orow_base + ROW_W'(1);
					end else begin
						rib_q  <= rib_base + CIB_W'(1);
						orow_q <= orow_base;
					end
				end else begin
					oc_q   <= oc_base + COL_W'(1);
					rib_q  <= rib_base;
					orow_q <= orow_base;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/bad_queue.sv
// short job queue between front and back end
`default_nettype none

module bad_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  bad_pkg::job_t     wr_job,
	input  wire               pop,
	output bad_pkg::job_t     rd_job,
	output bad_pkg::qstat_t   qstat
);
	import bad_pkg::*;

	job_t               entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;

	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rd_job      = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/bad_back.sv
// back end: line store accumulation, reciprocal division and output register
`default_nettype none

module bad_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [bad_pkg::SCALE_W-1:0]  scale_eff,
	input  bad_pkg::qstat_t             qstat,
	input  bad_pkg::job_t               head,
	output logic                        pop,
	output logic                        out_valid,
	input  wire                         out_ready,
	output bad_pkg::pix_out_t           out_data
);
	import bad_pkg::*;

	bstate_t            state_q;
	bstate_t            state_d;
	job_t               job_q;
	csum_t              line_mem [LINE_DEPTH];
	csum_t              rd_data_q;
	csum_t              col;
	csum_t              col_q;
	logic [QUO_W-1:0]   q0_q [LANES];
	logic [QUO_W-1:0]   q0 [LANES];
	logic [PIX_W-1:0]   mean [LANES];
	logic [PROD_W-1:0]  prod [LANES];
	logic [CHK_W-1:0]   chk [LANES];
	logic [CHK_W-1:0]   rem [LANES];
	logic [RECIP_W-1:0] recip;
	logic [DIV_W-1:0]   area;
	logic               out_valid_q;
	pix_out_t           out_data_q;
	logic               out_free;
	logic               rd_en;
	logic               wr_en;
	logic               load_col;
	logic               load_q0;
	logic               load_out;

	assign recip     = recip_of(scale_eff);
	assign area      = area_of(scale_eff);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					state_d = B_ADD;
				end
			end
			B_ADD: begin
				state_d = job_q.last_row ? B_MUL : B_IDLE;
			end
			B_MUL: begin
				state_d = B_FIX;
			end
			B_FIX: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop      = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		load_col = 1'b0;
		load_q0  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop   = !qstat.empty;
				rd_en = !qstat.empty;
			end
			B_ADD: begin
				wr_en    = !job_q.last_row;
				load_col = job_q.last_row;
			end
			B_MUL: begin
				load_q0 = 1'b1;
			end
			B_FIX: begin
				load_out = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// line store of partial column sums
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= line_mem[head.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[job_q.idx] <= col;
		end
	end

	// vertical accumulation, the top block row starts from zero
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			col[k] = CSUM_W'(job_q.hsum[k]) + (job_q.first_row ? '0 : rd_data_q[k]);
		end
	end

	// reciprocal estimate, at most one below the true quotient
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			prod[k] = PROD_W'(col_q[k]) * PROD_W'(recip);
			q0[k]   = prod[k][RECIP_SHIFT +: QUO_W];
		end
	end

	// one-step correction of the estimate
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			chk[k]  = CHK_W'(q0_q[k]) * CHK_W'(area);
			rem[k]  = CHK_W'(col_q[k]) - chk[k];
			mean[k] = (rem[k] >= CHK_W'(area)) ? q0_q[k][PIX_W-1:0] + PIX_W'(1)
			                                  : q0_q[k][PIX_W-1:0];
		end
	end

	// job and datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (load_col) begin
			col_q <= col;
		end
		if (load_q0) begin
			for (int k = 0; k < LANES; k++) begin
				q0_q[k] <= q0[k];
			end
		end
		if (load_out) begin
			out_data_q.red_out   <= mean[0];
			out_data_q.green_out <= mean[1];
			out_data_q.blue_out  <= mean[2];
			out_data_q.row_end   <= job_q.last_col;
			out_data_q.frame_end <= job_q.last_col && job_q.last_orow;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: sv/box_average_downscale.sv
// box_average_downscale: top level of the integer factor box filter downscaler
//
// Source pixels come in on in_valid/in_ready/in_data in raster order; every
// scale by scale block gives one output pixel on out_valid/out_ready/out_data
// holding the floor mean per colour lane plus row and frame end flags.
// The config port (cfg_we, cfg_index, cfg_data) must be written only while
// idle; the block does not enforce this. The front end takes one pixel per
// cycle while its four-entry job queue has room. The back end takes one job
// at a time: an upper block row run is a line store read, then add and write;
// a bottom row run is a read, add, one reciprocal multiply and a correction
// into the free output register. Sustained input is one pixel per cycle at
// scale 4 and up unless out_ready stalls; bottom block rows slow it at scales
// 2 and 3. A finished block passes the queue, line store read, col_q and q0_q
// before the output register raises out_valid. Reset restores scale 2, 640 by
// 480, clears counters, queue and output valid; the line store is not cleared,
// the top block row fills it. A stalled receiver holds the output register,
// then the queue fills and in_ready drops until the transaction is taken.
`default_nettype none

module box_average_downscale (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  bad_pkg::pix_in_t               in_data,
	output logic                           out_valid,
	input  wire                            out_ready,
	output bad_pkg::pix_out_t              out_data,
	input  wire                            cfg_we,
	input  wire [bad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [bad_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bad_pkg::*;

	logic [SCALE_W-1:0]  scale_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [SCALE_W-1:0]  scale_eff;
	logic [WIDTH_W-1:0]  width_eff;
	logic [HEIGHT_W-1:0] height_eff;
	qstat_t              qstat;
	logic                push;
	logic                pop;
	job_t                front_job;
	job_t                head_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SCALE) begin
				scale_q <= cfg_data[SCALE_W-1:0];
			end
			if (cfg_index == CFG_WIDTH) begin
				width_q <= cfg_data[WIDTH_W-1:0];
			end
			if (cfg_index == CFG_HEIGHT) begin
				height_q <= cfg_data[HEIGHT_W-1:0];
			end
		end
	end

	// out of range settings fold into the supported range
	assign scale_eff  = clamp_scale(scale_q);
	assign width_eff  = clamp_width(width_q);
	assign height_eff = clamp_height(height_q);

	bad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.scale_eff  (scale_eff),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.qstat      (qstat),
		.push       (push),
		.job        (front_job)
	);

	bad_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.pop    (pop),
		.rd_job (head_job),
		.qstat  (qstat)
	);

	bad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale_eff (scale_eff),
		.qstat     (qstat),
		.head      (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// checks
	`include "box_average_downscale_assert.svh"

	`BAD_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !qstat.full || pop)
	`BAD_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !qstat.empty)
	`BAD_ASSERT_IMP(a_frame_end_row_end, clk, arst_n, out_valid && out_data.frame_end, out_data.row_end)
	`BAD_ASSERT_NXT(a_job_gives_space, clk, arst_n, pop && !push, !qstat.full)

endmodule

`default_nettype wire
